// ===== design/jutf_pkg.sv =====
// Shared types, character codes and helpers for the unicode-escape decoder.
// No dependencies; imported by the front end, the packet queue and the back end.
`default_nettype none

package jutf_pkg;

    // Characters of an escape sequence
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U      = 8'h75;

    // UTF-8 range limits and lead/continuation marks
    localparam logic [15:0] UTF8_LIM1  = 16'h0080;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK6 = 8'h3F;

    // Bytes per packet and width of the byte count
    localparam int unsigned PKT_BYTES = 6;
    localparam int unsigned CNT_W     = 3;

    // Escape progress: idle, backslash held, 'u' held, one to three digits held
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BSL  = 3'd1,
        PH_U    = 3'd2,
        PH_D1   = 3'd3,
        PH_D2   = 3'd4,
        PH_D3   = 3'd5
    } phase_t;

    // Output run of one input beat: bytes in order, count and end-of-text mark
    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic                      last;
    } pkt_t;

    // Hex digit test: bit 4 flags a valid digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/jutf_front.sv =====
// Front end: accepts input beats, tracks escape progress and builds one
// output packet per beat. Depends on jutf_pkg.
`default_nettype none

module jutf_front
    import jutf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_char,
    input  wire logic       s_in_end,
    input  wire logic       q_full,
    output logic            push,
    output pkt_t            push_pkt
);

    phase_t           phase_reg, phase_next;
    logic [7:0]       held_reg [3];
    logic [2:0]       p;
    logic [4:0]       hd;
    logic [7:0]       held_seq [5];
    logic             is_adv, is_enc, accept;
    logic [15:0]      cp;
    logic [4:0]       d0, d1, d2;
    pkt_t             pkt;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign p       = phase_reg;

    always_comb begin
        hd = hex_decode(s_in_char);
        d0 = hex_decode(held_reg[0]);
        d1 = hex_decode(held_reg[1]);
        d2 = hex_decode(held_reg[2]);
        cp = {d0[3:0], d1[3:0], d2[3:0], hd[3:0]};

        held_seq[0] = CHAR_BSLASH;
        held_seq[1] = CHAR_U;
        held_seq[2] = held_reg[0];
        held_seq[3] = held_reg[1];
        held_seq[4] = held_reg[2];

        is_adv = (phase_reg == PH_IDLE && s_in_char == CHAR_BSLASH)
              || (phase_reg == PH_BSL && s_in_char == CHAR_U)
              || ((phase_reg == PH_U || phase_reg == PH_D1 || phase_reg == PH_D2)
                  && hd[4]);
        is_enc = (phase_reg == PH_D3) && hd[4];

        // Held characters first, then the current byte
        for (int k = 0; k < 5; k++) begin
            pkt.bytes[k] = (3'(k) < p) ? held_seq[k] : s_in_char;
        end
        pkt.bytes[5] = s_in_char;
        pkt.last     = s_in_end;

        if (is_enc) begin
            phase_next = PH_IDLE;
            if (cp < UTF8_LIM1) begin
                pkt.bytes[0] = cp[7:0];
                pkt.cnt      = 3'd1;
            end else if (cp < UTF8_LIM2) begin
                pkt.bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
                pkt.bytes[1] = UTF8_CONT | ({2'd0, cp[5:0]} & UTF8_MASK6);
                pkt.cnt      = 3'd2;
            end else begin
                pkt.bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
                pkt.bytes[1] = UTF8_CONT | ({2'd0, cp[11:6]} & UTF8_MASK6);
                pkt.bytes[2] = UTF8_CONT | ({2'd0, cp[5:0]} & UTF8_MASK6);
                pkt.cnt      = 3'd3;
            end
        end else if (is_adv) begin
            // Escape grows; flush it all if the text ends here
            phase_next = s_in_end ? PH_IDLE : phase_t'(p + 3'd1);
            pkt.cnt    = s_in_end ? p + 3'd1 : 3'd0;
        end else begin
            // Broken escape or plain byte: replay held, then the byte afresh
            phase_next = (s_in_char == CHAR_BSLASH && !s_in_end) ? PH_BSL : PH_IDLE;
            pkt.cnt    = p + {2'd0, (s_in_char != CHAR_BSLASH) || s_in_end};
        end
    end

    assign push     = accept && (pkt.cnt != 3'd0);
    assign push_pkt = pkt;

    // Advance escape progress on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    // Hold hex digits of the pending escape
    always_ff @(posedge aclk) begin
        if (accept && is_adv && p >= 3'd2) begin
            held_reg[2'(p - 3'd2)] <= s_in_char;
        end
    end

endmodule

`default_nettype wire

// ===== design/jutf_queue.sv =====
// Short packet queue between front and back ends.
// Depends on jutf_pkg for the packet type.
`default_nettype none

module jutf_queue
    import jutf_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  pkt_t      push_pkt,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output pkt_t      head_pkt
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    pkt_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_pkt  = mem[rd_ptr_reg];

    // Store incoming packets
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_pkt;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/jutf_back.sv =====
// Back end: walks the head packet one byte per beat into the output register.
// Depends on jutf_pkg for the packet type.
`default_nettype none

module jutf_back
    import jutf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       not_empty,
    input  pkt_t            head_pkt,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_run_last,
    output logic            m_stream_last
);

    logic [CNT_W-1:0] idx_reg;
    logic             m_valid_reg;
    logic [7:0]       byte_reg;
    logic             run_last_reg, stream_last_reg;
    logic             load, at_end;

    assign load   = not_empty && (!m_valid_reg || m_ready);
    assign at_end = (idx_reg == head_pkt.cnt - 1'b1);
    assign pop    = load && at_end;

    // Step through the packet and drop it after its final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg <= at_end ? '0 : idx_reg + 1'b1;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg        <= head_pkt.bytes[idx_reg];
            run_last_reg    <= at_end;
            stream_last_reg <= at_end && head_pkt.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_run_last    = run_last_reg;
    assign m_stream_last = stream_last_reg;

endmodule

`default_nettype wire

// ===== design/json_unicode_escape_to_utf8_unit.sv =====
// Top level of the JSON unicode-escape to UTF-8 decoder.
// Instantiates jutf_front, jutf_queue and jutf_back; depends on jutf_pkg.
//
// Input channel (s_valid/s_ready, s_in_char, s_in_end) takes one text byte
// per beat; s_in_end marks the last byte of a text. A backslash, 'u' and
// four hex digits become the 1-3 byte UTF-8 form of the code point; other
// bytes pass through, and a broken escape is replayed unchanged.
// Output channel (m_valid/m_ready) gives one byte per beat; m_run_last flags
// the last byte caused by an input beat, m_stream_last the last of a text.
// With the queue empty, the first byte of a beat's run passes through the packet
// queue into the output register, and m_valid rises as it is loaded there.
// Throughput: one input beat per cycle while the queue is not full, one output
// byte per cycle while m_ready is high, so beats that expand into several bytes
// fill the FIFO_DEPTH-entry packet queue, and s_ready drops while it is full.
// Beats that only extend an escape produce nothing and take no queue slot.
// A stalled receiver holds the output register; the queue then fills and
// stalls the input side. Reset clears escape progress, the queue and m_valid.
`default_nettype none

module json_unicode_escape_to_utf8_unit
    import jutf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_char,
    input  wire logic       s_in_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_run_last,
    output logic            m_stream_last
);

    logic push, pop, q_full, q_not_empty;
    pkt_t push_pkt, head_pkt;

    jutf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_char (s_in_char),
        .s_in_end  (s_in_end),
        .q_full    (q_full),
        .push      (push),
        .push_pkt  (push_pkt)
    );

    jutf_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_pkt  (push_pkt),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_pkt  (head_pkt)
    );

    jutf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .not_empty     (q_not_empty),
        .head_pkt      (head_pkt),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_stream_last (m_stream_last)
    );

    // End of text always closes a run
    a_stream_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_last |-> m_run_last)
        else $error("stream_last without run_last");

    // No packet written into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!q_full || pop))
        else $error("packet queue overflow");

    // Only a present packet is consumed
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_not_empty)
        else $error("packet queue underflow");

    // Output channel empty right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
